// ===== src/bsgf_pkg.sv =====
// Shared types and constants for the bitmap set/get/find-first block.
package bsgf_pkg;

    localparam int FIELD_W   = 13;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        CMD_GET  = 2'd0,
        CMD_SET  = 2'd1,
        CMD_FIND = 2'd2,
        CMD_SIZE = 2'd3
    } cmd_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_LIMIT = 2'd2;

    typedef struct packed {
        logic first;   // word holds the start of the range
        logic last;    // word holds the last bit of the range
        logic value;   // bit value being searched for
    } scan_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;
    } scan_res_t;

endpackage

// ===== src/bitmap_set_get_find_first.sv =====
// Top level: command sequencer, size/limit registers and output register.
//
// Bit store of CAPACITY_BITS bits held in a 32-bit-wide memory, with a logical size and a
// max-size limit written through cfg_wen/cfg_wdata (0 or anything above capacity makes the
// capacity the limit). One command is in flight at a time. After reset the memory is swept
// to zero, one word per cycle, while s_tready stays low. Set size and any command that fails
// its range check go straight to the response; get reads one word, and set does a
// read-modify-write of one word. A find scans words from the start word up to the first word
// holding a match or the last word of the clamped range; the memory's single read port
// delivers one word per cycle. A finished result sits in the output register, so the next
// command is accepted while it waits for m_tready.
module bitmap_set_get_find_first #(
    parameter int CAPACITY_BITS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: max_size
    input  logic        cfg_wen,
    input  logic [12:0] cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // index[12:0], value[13], end_index[26:14], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // bit_value[0], found_index[13:1], size[26:14], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int NUM_WORDS = (CAPACITY_BITS + bsgf_pkg::WORD_BITS - 1) / bsgf_pkg::WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SZ_W      = ($clog2(CAPACITY_BITS + 1) > bsgf_pkg::FIELD_W + 1)
                               ? $clog2(CAPACITY_BITS + 1) : bsgf_pkg::FIELD_W + 1;
    localparam int WIW       = SZ_W - bsgf_pkg::BIT_W;
    localparam logic [SZ_W-1:0] CAP_SZ   = SZ_W'(CAPACITY_BITS);
    localparam logic [AW-1:0]   LAST_ADR = AW'(NUM_WORDS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_GET   = 6'b000100,
        S_SETW  = 6'b001000,
        S_FIND  = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  clr_cnt_reg, clr_cnt_next;
    logic [SZ_W-1:0]                size_reg, size_next;
    logic [bsgf_pkg::FIELD_W-1:0]   max_reg;
    logic [bsgf_pkg::FIELD_W-1:0]   idx_reg, idx_next;
    logic                           val_reg, val_next;
    logic [SZ_W-1:0]                endc_reg, endc_next;
    logic [WIW-1:0]                 cur_w_reg, cur_w_next;
    logic [WIW-1:0]                 first_w_reg, first_w_next;
    logic [WIW-1:0]                 last_w_reg, last_w_next;
    logic [1:0]                     res_status_reg, res_status_next;
    logic                           res_bit_reg, res_bit_next;
    logic [SZ_W-1:0]                res_found_reg, res_found_next;
    logic                           m_valid_reg, m_valid_next;
    logic [31:0]                    m_data_reg, m_data_next;
    logic [1:0]                     m_user_reg, m_user_next;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [bsgf_pkg::WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [bsgf_pkg::WORD_BITS-1:0] ram_q;

    bsgf_pkg::scan_ctl_t            scan_ctl;
    bsgf_pkg::scan_res_t            scan_res;

    logic                           in_acc;
    bsgf_pkg::cmd_t                 in_cmd;
    logic [SZ_W-1:0]                in_idx;
    logic [SZ_W-1:0]                in_end;
    logic [SZ_W-1:0]                in_endc;
    logic [SZ_W-1:0]                in_endc_m1;
    logic [SZ_W-1:0]                limit;
    logic [SZ_W-1:0]                max_ext;
    logic [SZ_W-1:0]                idx_reg_ext;
    logic [SZ_W-1:0]                endc_m1_reg;
    logic                           out_load;

    bsgf_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign endc_m1_reg = endc_reg - SZ_W'(1);
    assign idx_reg_ext = SZ_W'(idx_reg);

    assign scan_ctl.first = (cur_w_reg == first_w_reg);
    assign scan_ctl.last  = (cur_w_reg == last_w_reg);
    assign scan_ctl.value = val_reg;

    bsgf_word_scan u_scan (
        .word (ram_q),
        .lo   (idx_reg[bsgf_pkg::BIT_W-1:0]),
        .hi   (endc_m1_reg[bsgf_pkg::BIT_W-1:0]),
        .ctl  (scan_ctl),
        .res  (scan_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_cmd   = bsgf_pkg::cmd_t'(s_tuser);
    assign in_idx   = SZ_W'(s_tdata[12:0]);
    assign in_end   = SZ_W'(s_tdata[26:14]);
    assign in_endc  = (in_end > size_reg) ? size_reg : in_end;
    assign in_endc_m1 = in_endc - SZ_W'(1);
    assign max_ext  = SZ_W'(max_reg);
    assign limit    = (max_reg == '0 || max_ext > CAP_SZ) ? CAP_SZ : max_ext;
    assign out_load = (state_reg == S_RESP) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        size_next       = size_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        endc_next       = endc_reg;
        cur_w_next      = cur_w_reg;
        first_w_next    = first_w_reg;
        last_w_next     = last_w_reg;
        res_status_next = res_status_reg;
        res_bit_next    = res_bit_reg;
        res_found_next  = res_found_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg_ext[bsgf_pkg::BIT_W +: AW];
        ram_wdata       = ram_q;
        ram_raddr       = AW'(cur_w_reg + WIW'(1));

        case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    idx_next        = s_tdata[12:0];
                    val_next        = s_tdata[13];
                    endc_next       = in_endc;
                    res_status_next = bsgf_pkg::STAT_OK;
                    res_bit_next    = 1'b0;
                    res_found_next  = '0;
                    ram_raddr       = in_idx[bsgf_pkg::BIT_W +: AW];
                    case (in_cmd)
                        bsgf_pkg::CMD_GET: begin
                            if (in_idx >= size_reg) begin
                                res_status_next = bsgf_pkg::STAT_RANGE;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_GET;
                            end
                        end
                        bsgf_pkg::CMD_SET: begin
                            if (in_idx >= size_reg && (in_idx + SZ_W'(1)) > limit) begin
                                res_status_next = bsgf_pkg::STAT_LIMIT;
                                state_next      = S_RESP;
                            end else begin
                                if (in_idx >= size_reg) begin
                                    size_next = in_idx + SZ_W'(1);
                                end
                                state_next = S_SETW;
                            end
                        end
                        bsgf_pkg::CMD_FIND: begin
                            first_w_next = in_idx[SZ_W-1:bsgf_pkg::BIT_W];
                            last_w_next  = in_endc_m1[SZ_W-1:bsgf_pkg::BIT_W];
                            cur_w_next   = in_idx[SZ_W-1:bsgf_pkg::BIT_W];
                            if (in_idx >= in_endc) begin
                                res_found_next = in_endc;
                                state_next     = S_RESP;
                            end else begin
                                state_next = S_FIND;
                            end
                        end
                        default: begin
                            // set size
                            if (in_idx != size_reg) begin
                                if (in_idx > limit) begin
                                    res_status_next = bsgf_pkg::STAT_LIMIT;
                                end else begin
                                    size_next = in_idx;
                                end
                            end
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_GET: begin
                res_bit_next = ram_q[idx_reg[bsgf_pkg::BIT_W-1:0]];
                state_next   = S_RESP;
            end
            S_SETW: begin
                ram_we = 1'b1;
                ram_wdata[idx_reg[bsgf_pkg::BIT_W-1:0]] = val_reg;
                state_next = S_RESP;
            end
            S_FIND: begin
                // word cur_w is on ram_q; cur_w+1 is read in the same cycle
                if (scan_res.hit) begin
                    res_found_next = {cur_w_reg, scan_res.pos};
                    state_next     = S_RESP;
                end else if (scan_ctl.last) begin
                    res_found_next = endc_reg;
                    state_next     = S_RESP;
                end else begin
                    cur_w_next = cur_w_reg + WIW'(1);
                end
            end
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_user_next  = res_status_reg;
            m_data_next  = {5'b0, size_reg[12:0], res_found_reg[12:0], res_bit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            size_reg    <= '0;
            max_reg     <= 13'd4096;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            size_reg    <= size_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                max_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        endc_reg       <= endc_next;
        cur_w_reg      <= cur_w_next;
        first_w_reg    <= first_w_next;
        last_w_reg     <= last_w_next;
        res_status_reg <= res_status_next;
        res_bit_reg    <= res_bit_next;
        res_found_reg  <= res_found_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== src/bsgf_ram.sv =====
// Single-port-write, single-port-read word memory with registered read data.
module bsgf_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [bsgf_pkg::WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]                  raddr,
    output logic [bsgf_pkg::WORD_BITS-1:0] rdata
);

    logic [bsgf_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [bsgf_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bsgf_word_scan.sv =====
// Masked first-match search within one memory word.
module bsgf_word_scan (
    input  logic [bsgf_pkg::WORD_BITS-1:0] word,
    input  logic [bsgf_pkg::BIT_W-1:0]     lo,
    input  logic [bsgf_pkg::BIT_W-1:0]     hi,
    input  bsgf_pkg::scan_ctl_t            ctl,
    output bsgf_pkg::scan_res_t            res
);

    logic [bsgf_pkg::WORD_BITS-1:0] sel;
    logic [bsgf_pkg::WORD_BITS-1:0] lo_mask;
    logic [bsgf_pkg::WORD_BITS-1:0] hi_mask;
    logic [bsgf_pkg::WORD_BITS-1:0] hits;

    always_comb begin
        sel     = ctl.value ? word : ~word;
        lo_mask = ctl.first ? ({bsgf_pkg::WORD_BITS{1'b1}} << lo)
                            : {bsgf_pkg::WORD_BITS{1'b1}};
        hi_mask = ctl.last  ? ({bsgf_pkg::WORD_BITS{1'b1}} >>
                               (bsgf_pkg::BIT_W'(bsgf_pkg::WORD_BITS - 1) - hi))
                            : {bsgf_pkg::WORD_BITS{1'b1}};
        hits    = sel & lo_mask & hi_mask;
        res.hit = |hits;
        res.pos = '0;
        // lowest set bit wins
        for (int k = bsgf_pkg::WORD_BITS - 1; k >= 0; k--) begin
            if (hits[k]) begin
                res.pos = bsgf_pkg::BIT_W'(k);
            end
        end
    end

endmodule

// ===== src/bsgf_checker.sv =====
// Port-level checker for the bitmap block, bound to the top level.
module bsgf_checker #(
    parameter int CAPACITY_BITS = 4096
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wen,
    input logic [12:0] cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // memory sweep keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open during memory clear");

    // one command in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

    // failed commands report no bit and no found index
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != bsgf_pkg::STAT_OK |-> m_tdata[13:0] == 14'd0)
        else $error("failed command carries data");

    a_size_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[26:14]) <= CAPACITY_BITS)
        else $error("size beyond capacity");

endmodule

bind bitmap_set_get_find_first bsgf_checker #(
    .CAPACITY_BITS (CAPACITY_BITS)
) u_bsgf_checker (.*);
